// ===== rtl/activation_and_gradient_unit_defines.svh =====
// Assertion macros shared by the activation and gradient unit.
// Expects clk and rst in the scope of each use.
`ifndef ACTIVATION_AND_GRADIENT_UNIT_DEFINES_SVH
`define ACTIVATION_AND_GRADIENT_UNIT_DEFINES_SVH

// same-cycle implication
`define AGU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("agu assertion failed");

// next-cycle implication
`define AGU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("agu assertion failed");

`endif

// ===== rtl/agu_pkg.sv =====
// Package for the activation and gradient unit: widths, codes and the
// sigmoid table built at elaboration. No dependencies.
package agu_pkg;

  localparam int VALUE_W    = 16;
  localparam int FRAC_BITS  = 12;
  localparam int SIG_DEPTH  = 256;
  localparam int ARG_LIMIT  = 27;
  localparam int SIG_W      = FRAC_BITS + 1;
  localparam int SIG_IDX_W  = $clog2(SIG_DEPTH + 1);
  localparam int ADDR_W     = 3;

  localparam logic [SIG_W-1:0] ONE_Q = SIG_W'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    MODE_IDENTITY = 2'd0,
    MODE_RELU     = 2'd1,
    MODE_CLIP     = 2'd2,
    MODE_SIGMOID  = 2'd3
  } act_mode_t;

  localparam logic REG_ACT_MODE = 1'b0;
  localparam logic REG_GAIN     = 1'b1;

  localparam logic [14:0] GAIN_RESET = 15'd4096;

  typedef logic [SIG_W-1:0] sig_rom_t [0:SIG_DEPTH];

  // e^-k for k = 0..8, 32 fraction bits
  typedef logic [63:0] exp_tab_t [0:8];
  localparam exp_tab_t EXP_NEG_INT = '{
    64'd4294967296, 64'd1580030169, 64'd581260616, 64'd213833830, 64'd78665070,
    64'd28939262, 64'd10646160, 64'd3916503, 64'd1440801
  };

  // restoring long division, table build only
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo, rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic sig_rom_t sig_build_rom();
    sig_rom_t   rom;
    logic [63:0] t, k, f, acc, term, e, d, q;
    for (int i = 0; i <= SIG_DEPTH; i++) begin
      t    = (64'(i) << 35) / SIG_DEPTH;
      k    = t >> 32;
      f    = t & 64'hFFFF_FFFF;
      acc  = 64'd1 << 32;
      term = 64'd1 << 32;
      if (k > 64'd8) k = 64'd8;
      for (int n = 1; n <= 13; n++) begin
        term = udiv64((term * f) >> 32, 64'(n));
        if ((n & 1) != 0) acc = (term <= acc) ? acc - term : 64'd0;
        else acc = acc + term;
      end
      if (acc > (64'd1 << 32)) acc = 64'd1 << 32;
      e = (EXP_NEG_INT[k[3:0]] * (acc >> 2)) >> 30;
      d = (64'd1 << 32) + e;
      q = udiv64((64'd1 << 44) + (d >> 1), d);
      rom[i] = q[SIG_W-1:0];
    end
    return rom;
  endfunction

  typedef struct packed {
    logic                       req;
    logic                       last;
    logic signed [VALUE_W-1:0]  g;
    logic signed [VALUE_W-1:0]  simple;
  } cmn_t;

endpackage

// ===== rtl/activation_and_gradient_unit.sv =====
// Activation and gradient unit: top level, nine-stage pipeline.
// Depends on agu_pkg and activation_and_gradient_unit_defines.svh.
//
// One item per cycle enters and leaves while m_tready is high; bubbles
// collapse, so the input keeps taking items while a result waits, until
// every stage is full. The sigmoid path sets the depth: gain multiply,
// table lookup of two neighbor points from a 257-entry constant table,
// interpolation multiply, then s*(1-s), the gain multiply and the gradient
// multiply, the last split into partial products. Write the registers only
// while no item is in flight.
`include "activation_and_gradient_unit_defines.svh"

module activation_and_gradient_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [agu_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // pre_activation, upstream_gradient
  input  logic                          s_tuser,   // req_type
  input  logic                          s_tlast,   // is_last
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // result_value
  output logic                          m_tuser,   // saturated
  output logic                          m_tlast    // is_last_out
);
  import agu_pkg::*;

  localparam int NST = 9;
  localparam sig_rom_t SIG_ROM = sig_build_rom();

  act_mode_t   act_mode;
  logic [14:0] gain;

  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  // configuration
  logic wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_mode <= MODE_IDENTITY;
      gain     <= GAIN_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_ACT_MODE: act_mode <= act_mode_t'(pwdata[1:0]);
        REG_GAIN:     gain     <= pwdata[14:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ACT_MODE: prdata = {30'd0, act_mode};
      REG_GAIN:     prdata = {17'd0, gain};
      default:      prdata = 32'd0;
    endcase
  end

  // stage handshake: advance a stage when empty or when the next one moves
  always_comb begin
    rdy[NST] = m_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end
  assign s_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= s_tvalid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 0: input register
  logic                      req0, last0;
  logic signed [VALUE_W-1:0] x0, g0;
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      req0  <= s_tuser;
      last0 <= s_tlast;
      x0    <= $signed(s_tdata[15:0]);
      g0    <= $signed(s_tdata[31:16]);
    end
  end

  // stage 1: gain product and the simple modes
  cmn_t               c [1:NST-1];
  logic signed [31:0] z1;
  logic signed [VALUE_W-1:0] simple0;
  logic x_pos, x_below_one;
  assign x_pos       = x0 > 0;
  assign x_below_one = x0 < $signed({3'd0, ONE_Q});

  always_comb begin
    if (!req0) begin
      case (act_mode)
        MODE_RELU: simple0 = x_pos ? x0 : '0;
        MODE_CLIP: simple0 = (x0 < 0) ? '0 :
                             (x_below_one ? x0 : $signed({3'd0, ONE_Q}));
        default:   simple0 = x0;
      endcase
    end else begin
      case (act_mode)
        MODE_RELU: simple0 = x_pos ? g0 : '0;
        MODE_CLIP: simple0 = (x_pos && x_below_one) ? g0 : '0;
        default:   simple0 = g0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      z1   <= $signed({1'b0, gain}) * x0;
      c[1] <= '{req: req0, last: last0, g: g0, simple: simple0};
    end
  end

  // stage 2: table lookup
  logic [31:0]            mag1;
  logic [ARG_LIMIT+SIG_IDX_W-1:0] p1;
  logic [SIG_IDX_W-1:0]   idx1;
  logic [SIG_W-1:0]       lo1, hi1;
  assign mag1 = z1[31] ? 32'(-z1) : 32'(z1);
  assign p1   = (ARG_LIMIT+SIG_IDX_W)'(mag1[ARG_LIMIT-1:0]) * SIG_DEPTH;
  assign idx1 = p1[ARG_LIMIT +: SIG_IDX_W];
  assign lo1  = SIG_ROM[idx1];
  assign hi1  = SIG_ROM[idx1 + SIG_IDX_W'(1)];

  logic [SIG_W-1:0]     lo2, diff2;
  logic [ARG_LIMIT-1:0] fr2;
  logic                 big2, zneg2;
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      lo2   <= lo1;
      diff2 <= (hi1 >= lo1) ? hi1 - lo1 : '0;
      fr2   <= p1[ARG_LIMIT-1:0];
      big2  <= mag1 >= (32'd1 << ARG_LIMIT);
      zneg2 <= z1[31];
      c[2]  <= c[1];
    end
  end

  // stage 3: interpolation product
  logic [SIG_W+ARG_LIMIT-1:0] prod3;
  logic [SIG_W-1:0]           lo3;
  logic                       big3, zneg3;
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      prod3 <= (SIG_W+ARG_LIMIT)'(diff2) * (SIG_W+ARG_LIMIT)'(fr2);
      lo3   <= lo2;
      big3  <= big2;
      zneg3 <= zneg2;
      c[3]  <= c[2];
    end
  end

  // stage 4: sigmoid value
  logic [SIG_W+ARG_LIMIT:0] rnd3;
  logic [SIG_W-1:0]         spos3, s4;
  assign rnd3  = {1'b0, prod3} + ((SIG_W+ARG_LIMIT+1)'(1) << (ARG_LIMIT - 1));
  assign spos3 = big3 ? ONE_Q : lo3 + rnd3[ARG_LIMIT +: SIG_W];
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4   <= zneg3 ? ONE_Q - spos3 : spos3;
      c[4] <= c[3];
    end
  end

  // stage 5: s * (1 - s)
  logic [2*SIG_W-1:0] q5;
  logic [SIG_W-1:0]   s5;
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      q5   <= (2*SIG_W)'(s4) * (2*SIG_W)'(ONE_Q - s4);
      s5   <= s4;
      c[5] <= c[4];
    end
  end

  // stage 6: gain * s * (1 - s), gradient magnitude
  logic [37:0]        dv6;
  logic [VALUE_W:0]   gm6;
  logic [SIG_W-1:0]   s6;
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      dv6  <= 38'(gain) * 38'(q5[22:0]);
      gm6  <= c[5].g[VALUE_W-1] ? (VALUE_W+1)'(-$signed({c[5].g[VALUE_W-1], c[5].g}))
                                : {1'b0, c[5].g};
      s6   <= s5;
      c[6] <= c[5];
    end
  end

  // stage 7: gradient partial products
  logic [35:0]      pl7, ph7;
  logic [SIG_W-1:0] s7;
  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      pl7  <= 36'(gm6) * 36'(dv6[18:0]);
      ph7  <= 36'(gm6) * 36'(dv6[37:19]);
      s7   <= s6;
      c[7] <= c[6];
    end
  end

  // stage 8: round, sign, clamp, select
  logic [55:0]        full7;
  logic [19:0]        m7;
  logic signed [20:0] r7;
  logic signed [VALUE_W-1:0] res7;
  logic               sat7;
  localparam logic signed [20:0] HI_LIM = 21'sd32767;
  localparam logic signed [20:0] LO_LIM = -21'sd32768;
  assign full7 = ({20'd0, ph7} << 19) + {20'd0, pl7} + (56'd1 << 35);
  assign m7    = full7[55:36];
  assign r7    = c[7].g[VALUE_W-1] ? -$signed({1'b0, m7}) : $signed({1'b0, m7});

  always_comb begin
    sat7 = 1'b0;
    if (act_mode != MODE_SIGMOID) begin
      res7 = c[7].simple;
    end else if (!c[7].req) begin
      res7 = $signed({3'd0, s7});
    end else if (r7 > HI_LIM) begin
      res7 = HI_LIM[VALUE_W-1:0];
      sat7 = 1'b1;
    end else if (r7 < LO_LIM) begin
      res7 = LO_LIM[VALUE_W-1:0];
      sat7 = 1'b1;
    end else begin
      res7 = r7[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      m_tdata <= res7;
      m_tuser <= sat7;
      m_tlast <= c[7].last;
      c[8]    <= c[7];
    end
  end

  assign m_tvalid = v[NST-1];

  `AGU_ASSERT_IMP(a_sat_only_sigmoid_bwd, m_tvalid && m_tuser,
                  act_mode == MODE_SIGMOID && c[8].req)
  `AGU_ASSERT_IMP(a_fwd_sigmoid_range, m_tvalid && act_mode == MODE_SIGMOID && !c[8].req,
                  !m_tdata[15] && m_tdata <= 16'(ONE_Q))
  `AGU_ASSERT_NXT(a_accept_fills_stage0, s_tvalid && s_tready, v[0])
  `AGU_ASSERT_NXT(a_stalled_output_holds, m_tvalid && !m_tready,
                  m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule
